// ===== src/chtab_pkg.sv =====
// chtab_pkg: types, constants and hash functions for the connection hash table
// shared by the hash unit, the bucket update logic, the checker and the top level
// no dependencies
package chtab_pkg;

  // table geometry
  localparam int NumBuckets = 1024;
  localparam int BucketWays = 4;
  localparam int SlotCount  = NumBuckets * BucketWays;
  localparam int BucketIdxW = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;

  // field widths
  localparam int ReqW         = 2;
  localparam int IpW          = 32;
  localparam int PortW        = 16;
  localparam int HandleW      = 16;
  localparam int StatusW      = 2;
  localparam int EntryCountW  = 13;
  localparam int CountW       = $clog2(SlotCount + 1);

  // hash key: address bytes first, then port low and high byte
  localparam int KeyW     = IpW + PortW;
  localparam int KeyBytes = KeyW / 8;
  localparam int HashCntW = $clog2(KeyBytes + 1);

  // request codes
  localparam logic [ReqW-1:0] REQ_INSERT = 2'd0;
  localparam logic [ReqW-1:0] REQ_REMOVE = 2'd1;
  localparam logic [ReqW-1:0] REQ_SEARCH = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatusW-1:0] STAT_FULL      = 2'd1;
  localparam logic [StatusW-1:0] STAT_NOT_FOUND = 2'd2;

  // one way of a bucket
  typedef struct packed {
    logic               valid;
    logic [IpW-1:0]     ip;
    logic [PortW-1:0]   port;
    logic [HandleW-1:0] handle;
  } way_t;

  localparam int WayBits = $bits(way_t);

  // one bucket, way 0 is the oldest entry
  typedef way_t [BucketWays-1:0] row_t;

  localparam int RowBits = $bits(row_t);

  // per-transaction result fields
  typedef struct packed {
    logic               hit;
    logic [HandleW-1:0] found_handle;
    logic [StatusW-1:0] status;
  } resp_t;

  // one byte step of the one-at-a-time hash
  function automatic logic [31:0] oat_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] a;
    logic [31:0] m;
    a = h + {24'd0, b};
    m = a + (a << 10);
    return m ^ (m >> 6);
  endfunction

  // final avalanche of the one-at-a-time hash
  function automatic logic [31:0] oat_final(input logic [31:0] h);
    logic [31:0] a;
    logic [31:0] x;
    a = h + (h << 3);
    x = a ^ (a >> 11);
    return x + (x << 15);
  endfunction

endpackage

// ===== src/connection_hash_table_top.sv =====
// connection_hash_table_top: connection table keyed by client address and port
// depends on chtab_pkg, chtab_hash, chtab_bucket_op, chtab_ram
//
// Usage
//   Request channel (req_valid / req_stall) carries req_type, src_addr,
//   src_port and conn_handle. A transaction is taken when req_valid is high
//   and req_stall is low. Each request gives exactly one response on the
//   response channel (resp_valid / resp_stall) with hit, found_handle, status
//   and entry_count, held stable while resp_stall is high.
//   Timing: the bucket index comes from a byte-serial hash unit (one key byte
//   per cycle, six bytes plus a final mix), then one read of the bucket ram and
//   one write-back. One request is in flight at a time, so a new request is
//   taken only after the previous one has finished.
//   Each bucket is one ram row of all its ways, so a request needs one read
//   and at most one write of a single row.
//   Reset: rst clears the control state and starts a clearing pass that
//   writes an empty row to every one of the NumBuckets (1024) buckets, with
//   req_stall held high throughout.
//   Response stall: a finished result waits in the output register; the block
//   already accepts and hashes the next request, and holds its write-back until
//   the output register is free.
module connection_hash_table_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [chtab_pkg::ReqW-1:0]          req_type,
  input  logic [chtab_pkg::IpW-1:0]           src_addr,
  input  logic [chtab_pkg::PortW-1:0]         src_port,
  input  logic [chtab_pkg::HandleW-1:0]       conn_handle,
  output logic                                resp_valid,
  input  logic                                resp_stall,
  output logic                                hit,
  output logic [chtab_pkg::HandleW-1:0]       found_handle,
  output logic [chtab_pkg::StatusW-1:0]       status,
  output logic [chtab_pkg::EntryCountW-1:0]   entry_count
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_HASH   = 2'd1;
  localparam logic [1:0] S_MODIFY = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // captured request
  logic [chtab_pkg::ReqW-1:0]    req_q;
  logic [chtab_pkg::IpW-1:0]     ip_q;
  logic [chtab_pkg::PortW-1:0]   port_q;
  logic [chtab_pkg::HandleW-1:0] handle_q;

  logic [chtab_pkg::CountW-1:0]     live;
  logic                             clr_busy;
  logic [chtab_pkg::BucketIdxW-1:0] clr_addr;

  logic                             req_accept;
  logic                             hash_done;
  logic [chtab_pkg::BucketIdxW-1:0] bucket_idx;
  logic                             rd_en;
  chtab_pkg::row_t                  rd_row;
  chtab_pkg::row_t                  upd_row;
  logic                             upd_wr;
  chtab_pkg::resp_t                 upd_resp;
  logic [chtab_pkg::CountW-1:0]     upd_count;
  logic                             out_free;
  logic                             finish;
  logic                             wr_en;
  logic [chtab_pkg::BucketIdxW-1:0] wr_addr;
  chtab_pkg::row_t                  wr_row;

  assign req_stall  = clr_busy || (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign out_free   = !resp_valid || !resp_stall;
  assign finish     = (state == S_MODIFY) && out_free;
  assign rd_en      = (state == S_HASH) && hash_done;

  // request capture
  always_ff @(posedge clk) begin
    if (req_accept) begin
      req_q    <= req_type;
      ip_q     <= src_addr;
      port_q   <= src_port;
      handle_q <= conn_handle;
    end
  end

  // hash runs on the captured key, the request ports may move on after acceptance
  chtab_hash u_hash (
    .clk        (clk),
    .rst        (rst),
    .start      (req_accept),
    .key        ({port_q, ip_q}),
    .done       (hash_done),
    .bucket_idx (bucket_idx)
  );

  chtab_bucket_op u_bucket_op (
    .req_type    (req_q),
    .src_addr    (ip_q),
    .src_port    (port_q),
    .conn_handle (handle_q),
    .row_in      (rd_row),
    .count_in    (live),
    .row_out     (upd_row),
    .wr_needed   (upd_wr),
    .resp        (upd_resp),
    .count_next  (upd_count)
  );

  // ram write: clearing pass or bucket write-back
  always_comb begin
    if (clr_busy) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_row  = '0;
    end else begin
      wr_en   = finish && upd_wr;
      wr_addr = bucket_idx;
      wr_row  = upd_row;
    end
  end

  chtab_ram #(
    .Width (chtab_pkg::RowBits),
    .Depth (chtab_pkg::NumBuckets)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_en   (rd_en),
    .rd_addr (bucket_idx),
    .rd_data (rd_row)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_accept) state_next = S_HASH;
      end
      S_HASH: begin
        if (hash_done) state_next = S_MODIFY;
      end
      S_MODIFY: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == chtab_pkg::BucketIdxW'(chtab_pkg::NumBuckets - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_addr <= clr_addr + chtab_pkg::BucketIdxW'(1);
    end
  end

  // live entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (finish) begin
      live <= upd_count;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (finish) begin
      resp_valid <= 1'b1;
    end else if (!resp_stall) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      hit          <= upd_resp.hit;
      found_handle <= upd_resp.found_handle;
      status       <= upd_resp.status;
      entry_count  <= chtab_pkg::EntryCountW'(upd_count);
    end
  end

endmodule

// ===== src/chtab_ram.sv =====
// chtab_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module chtab_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
  input  logic [Width-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
  output logic [Width-1:0]                         rd_data
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered, data holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/chtab_hash.sv =====
// chtab_hash: byte-serial one-at-a-time hash giving the bucket index
// depends on chtab_pkg
module chtab_hash (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [chtab_pkg::KeyW-1:0]       key,
  output logic                             done,
  output logic [chtab_pkg::BucketIdxW-1:0] bucket_idx
);

  logic                           busy;
  logic [chtab_pkg::HashCntW-1:0] cnt;
  logic [31:0]                    h;
  logic [7:0]                     cur_byte;
  logic [31:0]                    h_final;

  // pick the key byte for this step
  always_comb begin
    cur_byte = '0;
    for (int k = 0; k < chtab_pkg::KeyBytes; k++) begin
      if (cnt == chtab_pkg::HashCntW'(k)) begin
        cur_byte = key[8*k +: 8];
      end
    end
  end

  assign h_final = chtab_pkg::oat_final(h);

  // one byte per cycle, then the final mix and mask
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        h    <= '0;
      end else if (busy) begin
        if (cnt == chtab_pkg::HashCntW'(chtab_pkg::KeyBytes)) begin
          busy       <= 1'b0;
          done       <= 1'b1;
          bucket_idx <= chtab_pkg::BucketIdxW'(h_final & 32'(chtab_pkg::NumBuckets - 1));
        end else begin
          h   <= chtab_pkg::oat_step(h, cur_byte);
          cnt <= cnt + chtab_pkg::HashCntW'(1);
        end
      end
    end
  end

endmodule

// ===== src/chtab_bucket_op.sv =====
// chtab_bucket_op: applies insert, remove or search to one bucket row
// depends on chtab_pkg
module chtab_bucket_op (
  input  logic [chtab_pkg::ReqW-1:0]    req_type,
  input  logic [chtab_pkg::IpW-1:0]     src_addr,
  input  logic [chtab_pkg::PortW-1:0]   src_port,
  input  logic [chtab_pkg::HandleW-1:0] conn_handle,
  input  chtab_pkg::row_t               row_in,
  input  logic [chtab_pkg::CountW-1:0]  count_in,
  output chtab_pkg::row_t               row_out,
  output logic                          wr_needed,
  output chtab_pkg::resp_t              resp,
  output logic [chtab_pkg::CountW-1:0]  count_next
);

  logic [chtab_pkg::BucketWays-1:0] key_match;
  logic [chtab_pkg::BucketWays-1:0] rm_match;

  // per-way compares
  always_comb begin
    for (int w = 0; w < chtab_pkg::BucketWays; w++) begin
      key_match[w] = row_in[w].valid && (row_in[w].ip == src_addr) &&
                     (row_in[w].port == src_port);
      rm_match[w]  = key_match[w] && (row_in[w].handle == conn_handle);
    end
  end

  // candidate rows and the result for each request
  always_comb begin
    chtab_pkg::row_t             ins_row;
    chtab_pkg::row_t             rm_row;
    chtab_pkg::row_t             shifted;
    logic                        ins_done;
    logic                        rm_seen;
    logic                        srch_hit;
    logic [chtab_pkg::HandleW-1:0] srch_handle;

    // insert at the first free way
    ins_row  = row_in;
    ins_done = 1'b0;
    for (int w = 0; w < chtab_pkg::BucketWays; w++) begin
      if (!ins_done && !row_in[w].valid) begin
        ins_row[w].valid  = 1'b1;
        ins_row[w].ip     = src_addr;
        ins_row[w].port   = src_port;
        ins_row[w].handle = conn_handle;
        ins_done          = 1'b1;
      end
    end

    // remove the oldest full match and close the gap
    shifted = chtab_pkg::row_t'(row_in >> chtab_pkg::WayBits);
    rm_row  = row_in;
    rm_seen = 1'b0;
    for (int w = 0; w < chtab_pkg::BucketWays; w++) begin
      if (rm_match[w]) begin
        rm_seen = 1'b1;
      end
      if (rm_seen) begin
        rm_row[w] = shifted[w];
      end
    end

    // oldest key match
    srch_hit    = 1'b0;
    srch_handle = '0;
    for (int w = 0; w < chtab_pkg::BucketWays; w++) begin
      if (!srch_hit && key_match[w]) begin
        srch_hit    = 1'b1;
        srch_handle = row_in[w].handle;
      end
    end

    row_out    = row_in;
    wr_needed  = 1'b0;
    resp       = '0;
    count_next = count_in;
    unique case (req_type)
      chtab_pkg::REQ_INSERT: begin
        if (ins_done) begin
          row_out    = ins_row;
          wr_needed  = 1'b1;
          count_next = count_in + chtab_pkg::CountW'(1);
          resp.status = chtab_pkg::STAT_OK;
        end else begin
          resp.status = chtab_pkg::STAT_FULL;
        end
      end
      chtab_pkg::REQ_REMOVE: begin
        if (rm_seen) begin
          row_out     = rm_row;
          wr_needed   = 1'b1;
          resp.hit    = 1'b1;
          resp.status = chtab_pkg::STAT_OK;
          if (count_in != '0) begin
            count_next = count_in - chtab_pkg::CountW'(1);
          end
        end else begin
          resp.status = chtab_pkg::STAT_NOT_FOUND;
        end
      end
      chtab_pkg::REQ_SEARCH: begin
        if (srch_hit) begin
          resp.hit          = 1'b1;
          resp.found_handle = srch_handle;
          resp.status       = chtab_pkg::STAT_OK;
        end else begin
          resp.status = chtab_pkg::STAT_NOT_FOUND;
        end
      end
      default: begin
        // undefined request: table untouched, status ok
        resp.status = chtab_pkg::STAT_OK;
      end
    endcase
  end

endmodule

// ===== src/chtab_checker.sv =====
// chtab_checker: port-level checks for the connection hash table, bound to the top
// depends on chtab_pkg and connection_hash_table_top
module chtab_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_stall,
  input logic                              resp_valid,
  input logic                              resp_stall,
  input logic                              hit,
  input logic [chtab_pkg::HandleW-1:0]     found_handle,
  input logic [chtab_pkg::StatusW-1:0]     status
);

  // a stalled response stays
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp_stall |=> resp_valid)
    else $error("response dropped while stalled");

  // a hit is always reported with status ok
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    resp_valid && hit |-> status == chtab_pkg::STAT_OK)
    else $error("hit with non-ok status");

  // a nonzero handle only comes with a hit
  a_handle_hit: assert property (@(posedge clk) disable iff (rst)
    resp_valid && (found_handle != '0) |-> hit)
    else $error("handle returned without a hit");

  // one request in flight: the channel stalls after each transaction
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken while busy");

endmodule

bind connection_hash_table_top chtab_checker u_chtab_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_stall    (req_stall),
  .resp_valid   (resp_valid),
  .resp_stall   (resp_stall),
  .hit          (hit),
  .found_handle (found_handle),
  .status       (status)
);
